// ===== rtl/core/bdi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BDI size estimator package
// Shared types, constants and sub-word helpers for the BDI size estimator.
// ----------------------------------------------------------------------------
package bdi_pkg;

    // Line geometry.
    localparam int LINE_WORDS = 8;
    localparam int LW_BITS    = $clog2(LINE_WORDS);
    localparam int IDX_BITS   = 5;     // index of a sub-word, up to 32 per line

    // Result and cost constants.
    localparam logic [9:0]  UNCOMP_BITS = 10'd512;
    localparam int          COST_BITS   = 12;
    localparam logic [COST_BITS-1:0] SIZE_FIELD_BITS = COST_BITS'(6 * 2 + 2);
    localparam logic [63:0] MAG_LIMIT   = 64'h8000_0000_0000_0000;

    // Base size codes: 0 is 2 bytes, 1 is 4 bytes, 2 is 8 bytes, 3 means all done.
    localparam logic [1:0] SZ_DONE = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ALG_SEL = 2'd0;
    localparam logic [1:0] CFG_BASE_EN = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_BASE_RD,
        S_BASE_LAT,
        S_DAT_RD,
        S_EX1,
        S_EX2,
        S_COST
    } t_state;

    // Buffer word that holds a given sub-word.
    function automatic logic [LW_BITS-1:0] word_addr(input logic [1:0] sz,
                                                     input logic [IDX_BITS-1:0] idx);
        logic [LW_BITS-1:0] a;
        case (sz)
            2'd0:    a = idx[4:2];
            2'd1:    a = idx[3:1];
            default: a = idx[2:0];
        endcase
        return a;
    endfunction

    // Zero-extended sub-word taken out of its buffer word.
    function automatic logic [63:0] sub_word(input logic [1:0] sz,
                                             input logic [IDX_BITS-1:0] idx,
                                             input logic [63:0] w);
        logic [63:0] v;
        case (sz)
            2'd0:    v = {48'd0, w[16*idx[1:0] +: 16]};
            2'd1:    v = {32'd0, w[32*idx[0] +: 32]};
            default: v = w;
        endcase
        return v;
    endfunction

    // Last sub-word index for a base size.
    function automatic logic [IDX_BITS-1:0] last_idx(input logic [1:0] sz);
        return IDX_BITS'((32 >> sz) - 1);
    endfunction

    // Delta width: zero for zero, else magnitude bit length plus a sign bit.
    function automatic logic [6:0] delta_bits(input logic [63:0] mag);
        logic [6:0] n;
        n = 7'd0;
        for (int i = 0; i < 64; i++) begin
            if (mag[i]) begin
                n = 7'(i + 2);
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/bdi_compressed_size_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BDI compressed size estimator
// Collects a cache line and reports its smallest base-delta-immediate size.
// ----------------------------------------------------------------------------
// Usage:
//   Words of a line are sent on i_line_word with i_start; a word is taken at
//   an edge where i_start is high and o_busy is low. The word with
//   i_last_word high starts the size search. Other words leave it ready.
//   The result appears on o_compressed_bits with o_done high for one cycle;
//   the receiver cannot stall it, and o_busy stays high through that cycle.
//   After the last word each base size passes through S_PICK; for an enabled
//   size, with nw = 32, 16, 8 sub-words for base sizes of 2, 4, 8 bytes,
//   each of the nw sub-words is read as base (S_BASE_RD, S_BASE_LAT), all nw
//   sub-words are scanned against it (S_DAT_RD, S_EX1, S_EX2) and S_COST
//   follows; a scan stops early at the magnitude limit. S_PICK ends the search.
//   One shared subtract/compare datapath and the single read port of the line
//   buffer set this sequence. With algorithm select low no size is tried.
//   Configuration writes go through i_cfg_we, i_cfg_idx, i_cfg_data; the user
//   must make them only while idle, as the block itself does not enforce it.
//   Reset clears the control state and the write position and restores the
//   register defaults; buffer contents are undefined until written.
module bdi_compressed_size_estimator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [63:0] i_line_word,
    input  logic        i_last_word,
    output logic        o_done,
    output logic [9:0]  o_compressed_bits,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [2:0]  i_cfg_data
);
    import bdi_pkg::*;

    t_state r_state, n_state;

    logic [63:0]          r_mem [LINE_WORDS];
    logic [63:0]          r_rd_data;
    logic [LW_BITS-1:0]   w_rd_addr;
    logic [LW_BITS-1:0]   r_wcnt;
    logic                 r_alg_sel;
    logic [2:0]           r_base_en;

    logic [1:0]           r_sz, n_sz;
    logic [IDX_BITS-1:0]  r_b, n_b, r_d, n_d;
    logic [63:0]          r_base, n_base;
    logic [63:0]          r_mb, n_mb, r_mi, n_mi;
    logic                 r_brk, n_brk;
    logic [5:0]           r_nb, n_nb, r_ni, n_ni;
    logic [6:0]           r_wb, n_wb, r_wi, n_wi;
    logic [9:0]           r_best, n_best;

    logic                 w_accept;
    logic [63:0]          w_data, w_diff;
    logic [6:0]           w_dsz;
    logic [COST_BITS-1:0] w_cost;

    assign w_accept = i_start && (r_state == S_IDLE) && !o_done;

    // Line buffer write and single registered read port.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[r_wcnt] <= i_line_word;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Write position and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt    <= '0;
            r_alg_sel <= 1'b1;
            r_base_en <= 3'd6;
        end else begin
            if (w_accept) begin
                r_wcnt <= i_last_word ? '0 : r_wcnt + LW_BITS'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ALG_SEL: r_alg_sel <= i_cfg_data[0];
                    CFG_BASE_EN: r_base_en <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Result strobe follows the end of the search.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= (r_state != S_IDLE) && (n_state == S_IDLE);
        end
    end

    // Sequencer state and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_sz   <= n_sz;
        r_b    <= n_b;
        r_d    <= n_d;
        r_base <= n_base;
        r_mb   <= n_mb;
        r_mi   <= n_mi;
        r_brk  <= n_brk;
        r_nb   <= n_nb;
        r_ni   <= n_ni;
        r_wb   <= n_wb;
        r_wi   <= n_wi;
        r_best <= n_best;
    end

    // Shared datapath: sub-word extraction, delta, width and cost.
    always_comb begin
        w_data = sub_word(r_sz, r_d, r_rd_data);
        w_diff = w_data - r_base;
        w_dsz  = delta_bits((r_mb >= r_mi) ? r_mi : r_mb);
        w_cost = (COST_BITS'(16) << r_sz)
               + COST_BITS'(r_nb) * COST_BITS'(r_wb)
               + COST_BITS'(r_ni) * COST_BITS'(r_wi)
               + (COST_BITS'(32) >> r_sz)
               + SIZE_FIELD_BITS;
    end

    // Next state and datapath control.
    always_comb begin
        n_state   = r_state;
        n_sz      = r_sz;
        n_b       = r_b;
        n_d       = r_d;
        n_base    = r_base;
        n_mb      = r_mb;
        n_mi      = r_mi;
        n_brk     = r_brk;
        n_nb      = r_nb;
        n_ni      = r_ni;
        n_wb      = r_wb;
        n_wi      = r_wi;
        n_best    = r_best;
        w_rd_addr = word_addr(r_sz, r_d);
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_last_word) begin
                    n_best  = UNCOMP_BITS;
                    n_sz    = 2'd0;
                    n_state = S_PICK;
                    if (!r_alg_sel) begin
                        n_sz = SZ_DONE;
                    end
                end
            end
            S_PICK: begin
                if (r_sz == SZ_DONE) begin
                    n_state = S_IDLE;
                end else if (r_base_en[r_sz]) begin
                    n_b     = '0;
                    n_state = S_BASE_RD;
                end else begin
                    n_sz = r_sz + 2'd1;
                end
            end
            S_BASE_RD: begin
                w_rd_addr = word_addr(r_sz, r_b);
                n_state   = S_BASE_LAT;
            end
            S_BASE_LAT: begin
                n_base  = sub_word(r_sz, r_b, r_rd_data);
                n_d     = '0;
                n_nb    = '0;
                n_ni    = '0;
                n_wb    = '0;
                n_wi    = '0;
                n_state = S_DAT_RD;
            end
            S_DAT_RD: begin
                n_state = S_EX1;
            end
            S_EX1: begin
                n_mb    = w_diff[63] ? (~w_diff + 64'd1) : w_diff;
                n_mi    = w_data[63] ? (~w_data + 64'd1) : w_data;
                n_brk   = (w_diff == MAG_LIMIT) || (w_data == MAG_LIMIT);
                n_state = S_EX2;
            end
            S_EX2: begin
                if (r_brk) begin
                    n_state = S_COST;
                end else begin
                    // Ties go to the zero base.
                    if (r_mb >= r_mi) begin
                        n_ni = r_ni + 6'd1;
                        if (w_dsz > r_wi) begin
                            n_wi = w_dsz;
                        end
                    end else begin
                        n_nb = r_nb + 6'd1;
                        if (w_dsz > r_wb) begin
                            n_wb = w_dsz;
                        end
                    end
                    if (r_d == last_idx(r_sz)) begin
                        n_state = S_COST;
                    end else begin
                        n_d     = r_d + IDX_BITS'(1);
                        n_state = S_DAT_RD;
                    end
                end
            end
            S_COST: begin
                if (w_cost < {2'b00, r_best}) begin
                    n_best = w_cost[9:0];
                end
                if (r_b == last_idx(r_sz)) begin
                    n_sz    = r_sz + 2'd1;
                    n_state = S_PICK;
                end else begin
                    n_b     = r_b + IDX_BITS'(1);
                    n_state = S_BASE_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy            = (r_state != S_IDLE) || o_done;
    assign o_compressed_bits = r_best;

endmodule

// ===== rtl/core/bdi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BDI size estimator checker
// Port-level checks of the command handshake and the result strobe.
// ----------------------------------------------------------------------------
module bdi_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       i_last_word,
    input logic       o_done,
    input logic [9:0] o_compressed_bits
);

    // A result never exceeds the uncompressed size.
    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_compressed_bits <= 10'd512))
        else $error("result above uncompressed size");

    // The strobe lasts one cycle and frees the block.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !o_busy))
        else $error("result strobe not a single cycle");

    // A transfer of a middle word leaves the block ready.
    a_mid_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !i_last_word) |=> !o_busy)
        else $error("busy after a middle word");

    // A transfer of the last word starts the search.
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_last_word) |=> (o_busy && !o_done))
        else $error("search not started by last word");

endmodule

bind bdi_compressed_size_estimator bdi_checker u_bdi_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_start           (i_start),
    .o_busy            (o_busy),
    .i_last_word       (i_last_word),
    .o_done            (o_done),
    .o_compressed_bits (o_compressed_bits)
);
